// ===== design/imra_pkg.sv =====
// Shared types and constants for the I2C master register access block.
`timescale 1ns / 1ps

package imra_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned NUM_PHASES    = 13;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] CSR_DEV_ADDR  = 2'd0;
   localparam logic [1:0] CSR_FIRST_REG = 2'd1;
   localparam logic [1:0] CSR_BURST_LEN = 2'd2;
   localparam logic [1:0] CSR_HALF_PER  = 2'd3;

   localparam logic [1:0] TX_DEV_ADDR = 2'd0;
   localparam logic [1:0] TX_REG_ADDR = 2'd1;
   localparam logic [1:0] TX_PAYLOAD  = 2'd2;

   typedef enum logic [NUM_PHASES-1:0] {
      PH_IDLE    = 13'b0000000000001,
      PH_START_A = 13'b0000000000010,
      PH_START_B = 13'b0000000000100,
      PH_TX_LO   = 13'b0000000001000,
      PH_TX_HI   = 13'b0000000010000,
      PH_RS_A    = 13'b0000000100000,
      PH_RS_B    = 13'b0000001000000,
      PH_RS_C    = 13'b0000010000000,
      PH_RX_LO   = 13'b0000100000000,
      PH_RX_HI   = 13'b0001000000000,
      PH_STOP_A  = 13'b0010000000000,
      PH_STOP_B  = 13'b0100000000000,
      PH_STOP_C  = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      logic [7:0] device_write_address;
      logic [7:0] burst_first_register;
      logic [5:0] burst_length;
      logic [9:0] half_period_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_last;
   } rsp_type;

endpackage

// ===== design/i2c_master_register_access.sv =====
// Top level of the I2C master register access block.
// The result word for a request is loaded into the output register on accept.
// One request word per cycle when not stalled; the sequencer advances once per accepted word.
// Output register is a single stage; a request is taken whenever it is empty or being drained.
// Reset (synchronous, active high) returns the sequencer to idle with both lines released
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps

module i2c_master_register_access (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  imra_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output imra_pkg::rsp_type    rsp_data,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_write_data
);

   imra_pkg::cfg_type cfg;
   imra_pkg::rsp_type rsp_comb;
   imra_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   logic              accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   imra_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   imra_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cfg    (cfg),
      .req    (req_data),
      .rsp    (rsp_comb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_comb;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/imra_csr.sv =====
// Configuration register file for the I2C master register access block.
`timescale 1ns / 1ps

module imra_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_write_data,
   output imra_pkg::cfg_type    cfg
);

   imra_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_write_address <= 8'd208;
         cfg_ff.burst_first_register <= 8'd59;
         cfg_ff.burst_length         <= 6'd14;
         cfg_ff.half_period_ticks    <= 10'd100;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            imra_pkg::CSR_DEV_ADDR:  cfg_ff.device_write_address <= csr_write_data[7:0];
            imra_pkg::CSR_FIRST_REG: cfg_ff.burst_first_register <= csr_write_data[7:0];
            imra_pkg::CSR_BURST_LEN: cfg_ff.burst_length         <= csr_write_data[5:0];
            imra_pkg::CSR_HALF_PER:  cfg_ff.half_period_ticks    <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/imra_engine.sv =====
// Bus sequencer: per-tick SCL/SDA generation, byte shifting and read capture.
`timescale 1ns / 1ps

module imra_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  imra_pkg::cfg_type    cfg,
   input  imra_pkg::req_type    req,
   output imra_pkg::rsp_type    rsp
);

   imra_pkg::phase_type phase_ff, phase_in;
   logic [9:0] tick_ff, tick_in;
   logic [3:0] bit_ff, bit_in;
   logic [5:0] byte_ff, byte_in;
   logic [7:0] shift_ff, shift_in;
   logic       rd_ff, rd_in;
   logic [7:0] hreg_ff, hreg_in;
   logic [7:0] hdata_ff, hdata_in;

   function automatic logic [7:0] tx_byte(input logic [1:0] idx, input logic rd,
                                          input imra_pkg::cfg_type c,
                                          input logic [7:0] hreg,
                                          input logic [7:0] hdata);
      logic [7:0] b;
      if (idx == imra_pkg::TX_DEV_ADDR) b = c.device_write_address;
      else if (idx == imra_pkg::TX_REG_ADDR) b = rd ? c.burst_first_register : hreg;
      else b = rd ? (c.device_write_address + 8'd1) : hdata;
      return b;
   endfunction

   always_comb begin
      logic [9:0]  eff_half;
      logic [5:0]  eff_len;
      logic        last_rx;
      logic        seg_end;
      logic        busy;
      logic        scl;
      logic        sda;
      logic        rvalid;
      logic [7:0]  rbyte;
      logic        rlast;
      logic [5:0]  byte_nx;

      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      rd_in    = rd_ff;
      hreg_in  = hreg_ff;
      hdata_in = hdata_ff;
      rvalid   = 1'b0;
      rbyte    = 8'd0;
      rlast    = 1'b0;
      byte_nx  = 6'd0;

      if (phase_ff == imra_pkg::PH_IDLE &&
          (req.cmd == imra_pkg::CMD_WRITE || req.cmd == imra_pkg::CMD_READ)) begin
         rd_in    = (req.cmd == imra_pkg::CMD_READ);
         hreg_in  = req.register_address;
         hdata_in = req.write_data;
         tick_in  = 10'd0;
         bit_in   = 4'd0;
         byte_in  = 6'd0;
         shift_in = 8'd0;
         phase_in = imra_pkg::PH_START_A;
      end

      eff_half = (cfg.half_period_ticks == 10'd0) ? 10'd1 : cfg.half_period_ticks;
      eff_len  = (cfg.burst_length == 6'd0) ? 6'd1 : cfg.burst_length;
      last_rx  = ({1'b0, byte_in} + 7'd1) >= {1'b0, eff_len};

      unique case (phase_in)
         imra_pkg::PH_START_A: begin scl = 1'b1; sda = 1'b1; end
         imra_pkg::PH_START_B: begin scl = 1'b1; sda = 1'b0; end
         imra_pkg::PH_TX_LO: begin
            scl = 1'b0;
            sda = (bit_in < 4'(imra_pkg::BITS_PER_BYTE)) ? shift_in[7] : 1'b1;
         end
         imra_pkg::PH_TX_HI: begin
            scl = 1'b1;
            sda = (bit_in < 4'(imra_pkg::BITS_PER_BYTE)) ? shift_in[7] : 1'b1;
         end
         imra_pkg::PH_RS_A: begin scl = 1'b0; sda = 1'b1; end
         imra_pkg::PH_RS_B: begin scl = 1'b1; sda = 1'b1; end
         imra_pkg::PH_RS_C: begin scl = 1'b1; sda = 1'b0; end
         imra_pkg::PH_RX_LO: begin
            scl = 1'b0;
            sda = (bit_in < 4'(imra_pkg::BITS_PER_BYTE)) ? 1'b1 : last_rx;
         end
         imra_pkg::PH_RX_HI: begin
            scl = 1'b1;
            sda = (bit_in < 4'(imra_pkg::BITS_PER_BYTE)) ? 1'b1 : last_rx;
         end
         imra_pkg::PH_STOP_A: begin scl = 1'b0; sda = 1'b0; end
         imra_pkg::PH_STOP_B: begin scl = 1'b1; sda = 1'b0; end
         imra_pkg::PH_STOP_C: begin scl = 1'b1; sda = 1'b1; end
         default:             begin scl = 1'b1; sda = 1'b1; end
      endcase

      busy    = (phase_in != imra_pkg::PH_IDLE);
      seg_end = ({1'b0, tick_in} + 11'd1) >= {1'b0, eff_half};

      if (busy) begin
         if (phase_in == imra_pkg::PH_RX_HI && bit_in < 4'(imra_pkg::BITS_PER_BYTE) &&
             seg_end) begin
            shift_in = {shift_in[6:0], req.sda_in};
            if (bit_in == 4'(imra_pkg::BITS_PER_BYTE - 1)) begin
               rvalid = 1'b1;
               rbyte  = shift_in;
               rlast  = last_rx;
            end
         end
         if (seg_end) begin
            tick_in = 10'd0;
            unique case (phase_in)
               imra_pkg::PH_START_A: phase_in = imra_pkg::PH_START_B;
               imra_pkg::PH_START_B: begin
                  byte_in  = 6'd0;
                  bit_in   = 4'd0;
                  shift_in = tx_byte(imra_pkg::TX_DEV_ADDR, rd_in, cfg, hreg_in, hdata_in);
                  phase_in = imra_pkg::PH_TX_LO;
               end
               imra_pkg::PH_TX_LO: phase_in = imra_pkg::PH_TX_HI;
               imra_pkg::PH_TX_HI: begin
                  if (bit_in < 4'(imra_pkg::BITS_PER_BYTE)) begin
                     bit_in   = bit_in + 4'd1;
                     shift_in = {shift_in[6:0], 1'b0};
                     phase_in = imra_pkg::PH_TX_LO;
                  end else if (!rd_in) begin
                     if (byte_in < 6'd2) begin
                        byte_in  = byte_in + 6'd1;
                        bit_in   = 4'd0;
                        shift_in = tx_byte(byte_in[1:0], rd_in, cfg, hreg_in, hdata_in);
                        phase_in = imra_pkg::PH_TX_LO;
                     end else begin
                        phase_in = imra_pkg::PH_STOP_A;
                     end
                  end else if (byte_in == 6'd0) begin
                     byte_in  = 6'd1;
                     bit_in   = 4'd0;
                     shift_in = tx_byte(imra_pkg::TX_REG_ADDR, rd_in, cfg, hreg_in, hdata_in);
                     phase_in = imra_pkg::PH_TX_LO;
                  end else if (byte_in == 6'd1) begin
                     phase_in = imra_pkg::PH_RS_A;
                  end else begin
                     byte_in  = 6'd0;
                     bit_in   = 4'd0;
                     shift_in = 8'd0;
                     phase_in = imra_pkg::PH_RX_LO;
                  end
               end
               imra_pkg::PH_RS_A: phase_in = imra_pkg::PH_RS_B;
               imra_pkg::PH_RS_B: phase_in = imra_pkg::PH_RS_C;
               imra_pkg::PH_RS_C: begin
                  byte_in  = 6'd2;
                  bit_in   = 4'd0;
                  shift_in = tx_byte(imra_pkg::TX_PAYLOAD, rd_in, cfg, hreg_in, hdata_in);
                  phase_in = imra_pkg::PH_TX_LO;
               end
               imra_pkg::PH_RX_LO: phase_in = imra_pkg::PH_RX_HI;
               imra_pkg::PH_RX_HI: begin
                  if (bit_in < 4'(imra_pkg::BITS_PER_BYTE)) begin
                     bit_in   = bit_in + 4'd1;
                     phase_in = imra_pkg::PH_RX_LO;
                  end else begin
                     byte_nx = byte_in + 6'd1;
                     byte_in = byte_nx;
                     if (byte_nx >= eff_len || byte_nx == 6'd0) begin
                        phase_in = imra_pkg::PH_STOP_A;
                     end else begin
                        bit_in   = 4'd0;
                        shift_in = 8'd0;
                        phase_in = imra_pkg::PH_RX_LO;
                     end
                  end
               end
               imra_pkg::PH_STOP_A: phase_in = imra_pkg::PH_STOP_B;
               imra_pkg::PH_STOP_B: phase_in = imra_pkg::PH_STOP_C;
               default:             phase_in = imra_pkg::PH_IDLE;
            endcase
         end else begin
            tick_in = tick_in + 10'd1;
         end
      end

      rsp.scl        = scl;
      rsp.sda_out    = sda;
      rsp.busy_res   = busy;
      rsp.read_valid = rvalid;
      rsp.read_byte  = rbyte;
      rsp.read_last  = rlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= imra_pkg::PH_IDLE;
         tick_ff  <= 10'd0;
         bit_ff   <= 4'd0;
         byte_ff  <= 6'd0;
         shift_ff <= 8'd0;
         rd_ff    <= 1'b0;
         hreg_ff  <= 8'd0;
         hdata_ff <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         rd_ff    <= rd_in;
         hreg_ff  <= hreg_in;
         hdata_ff <= hdata_in;
      end
   end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the I2C master register access block, with a cycle-level bus predictor.
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_PCT = 34;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_WORDS = 1100;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   imra_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   imra_pkg::rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = imra_pkg::CSR_DEV_ADDR;
   logic [9:0] csr_write_data = '0;

   i2c_master_register_access u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // bus sequencer mirror
   imra_pkg::cfg_type cfg = '{8'd208, 8'd59, 6'd14, 10'd100};
   imra_pkg::phase_type bus_phase = imra_pkg::PH_IDLE;
   logic [9:0] tick_cnt = '0;
   logic [3:0] bit_cnt = '0;
   logic [5:0] byte_cnt = '0;
   logic [7:0] shreg = '0;
   logic reading = 1'b0;
   logic [7:0] hold_reg = '0;
   logic [7:0] hold_data = '0;
   logic scl_q = 1'b1;
   logic sda_q = 1'b1;

   imra_pkg::req_type words_to_send[$];
   imra_pkg::rsp_type lines_due[$];
   int sent_words = 0;
   int seen_words = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   function automatic int burst_bytes();
      return (cfg.burst_length == 6'd0) ? 1 : int'(cfg.burst_length);
   endfunction

   function automatic void load_byte(input logic [1:0] idx);
      byte_cnt = {4'd0, idx};
      bit_cnt = '0;
      if (idx == imra_pkg::TX_DEV_ADDR)
         shreg = cfg.device_write_address;
      else if (idx == imra_pkg::TX_REG_ADDR)
         shreg = reading ? cfg.burst_first_register : hold_reg;
      else
         shreg = reading ? cfg.device_write_address + 8'd1 : hold_data;
      bus_phase = imra_pkg::PH_TX_LO;
   endfunction

   function automatic imra_pkg::rsp_type i2c_tick(input imra_pkg::req_type r);
      imra_pkg::rsp_type o;
      logic last_rx;
      logic seg_end;
      int hp;
      o = '0;
      if (bus_phase == imra_pkg::PH_IDLE &&
          (r.cmd == imra_pkg::CMD_WRITE || r.cmd == imra_pkg::CMD_READ)) begin
         reading = (r.cmd == imra_pkg::CMD_READ);
         hold_reg = r.register_address;
         hold_data = r.write_data;
         tick_cnt = '0;
         bit_cnt = '0;
         byte_cnt = '0;
         shreg = '0;
         bus_phase = imra_pkg::PH_START_A;
      end
      last_rx = (int'(byte_cnt) + 1) >= burst_bytes();
      case (bus_phase)
         imra_pkg::PH_START_A: begin scl_q = 1'b1; sda_q = 1'b1; end
         imra_pkg::PH_START_B: begin scl_q = 1'b1; sda_q = 1'b0; end
         imra_pkg::PH_TX_LO, imra_pkg::PH_TX_HI: begin
            scl_q = (bus_phase == imra_pkg::PH_TX_HI);
            sda_q = (bit_cnt < 4'(imra_pkg::BITS_PER_BYTE)) ? shreg[7] : 1'b1;
         end
         imra_pkg::PH_RS_A: begin scl_q = 1'b0; sda_q = 1'b1; end
         imra_pkg::PH_RS_B: begin scl_q = 1'b1; sda_q = 1'b1; end
         imra_pkg::PH_RS_C: begin scl_q = 1'b1; sda_q = 1'b0; end
         imra_pkg::PH_RX_LO, imra_pkg::PH_RX_HI: begin
            scl_q = (bus_phase == imra_pkg::PH_RX_HI);
            sda_q = (bit_cnt < 4'(imra_pkg::BITS_PER_BYTE)) ? 1'b1 : last_rx;
         end
         imra_pkg::PH_STOP_A: begin scl_q = 1'b0; sda_q = 1'b0; end
         imra_pkg::PH_STOP_B: begin scl_q = 1'b1; sda_q = 1'b0; end
         default: begin scl_q = 1'b1; sda_q = 1'b1; end
      endcase
      o.scl = scl_q;
      o.sda_out = sda_q;
      o.busy_res = (bus_phase != imra_pkg::PH_IDLE);
      if (bus_phase != imra_pkg::PH_IDLE) begin
         hp = (cfg.half_period_ticks == 10'd0) ? 1 : int'(cfg.half_period_ticks);
         seg_end = (int'(tick_cnt) + 1) >= hp;
         if (bus_phase == imra_pkg::PH_RX_HI && bit_cnt < 4'(imra_pkg::BITS_PER_BYTE) &&
             seg_end) begin
            shreg = {shreg[6:0], r.sda_in};
            if (bit_cnt == 4'(imra_pkg::BITS_PER_BYTE - 1)) begin
               o.read_valid = 1'b1;
               o.read_byte = shreg;
               o.read_last = last_rx;
            end
         end
         if (!seg_end) begin
            tick_cnt = tick_cnt + 10'd1;
         end else begin
            tick_cnt = '0;
            case (bus_phase)
               imra_pkg::PH_START_A: bus_phase = imra_pkg::PH_START_B;
               imra_pkg::PH_START_B: load_byte(imra_pkg::TX_DEV_ADDR);
               imra_pkg::PH_TX_LO: bus_phase = imra_pkg::PH_TX_HI;
               imra_pkg::PH_TX_HI: begin
                  if (bit_cnt < 4'(imra_pkg::BITS_PER_BYTE)) begin
                     bit_cnt = bit_cnt + 4'd1;
                     shreg = {shreg[6:0], 1'b0};
                     bus_phase = imra_pkg::PH_TX_LO;
                  end else if (!reading) begin
                     if (byte_cnt < {4'd0, imra_pkg::TX_PAYLOAD})
                        load_byte(byte_cnt[1:0] + 2'd1);
                     else
                        bus_phase = imra_pkg::PH_STOP_A;
                  end else if (byte_cnt == {4'd0, imra_pkg::TX_DEV_ADDR}) begin
                     load_byte(imra_pkg::TX_REG_ADDR);
                  end else if (byte_cnt == {4'd0, imra_pkg::TX_REG_ADDR}) begin
                     bus_phase = imra_pkg::PH_RS_A;
                  end else begin
                     byte_cnt = '0;
                     bit_cnt = '0;
                     shreg = '0;
                     bus_phase = imra_pkg::PH_RX_LO;
                  end
               end
               imra_pkg::PH_RS_A: bus_phase = imra_pkg::PH_RS_B;
               imra_pkg::PH_RS_B: bus_phase = imra_pkg::PH_RS_C;
               imra_pkg::PH_RS_C: load_byte(imra_pkg::TX_PAYLOAD);
               imra_pkg::PH_RX_LO: bus_phase = imra_pkg::PH_RX_HI;
               imra_pkg::PH_RX_HI: begin
                  if (bit_cnt < 4'(imra_pkg::BITS_PER_BYTE)) begin
                     bit_cnt = bit_cnt + 4'd1;
                     bus_phase = imra_pkg::PH_RX_LO;
                  end else begin
                     byte_cnt = byte_cnt + 6'd1;
                     if (int'(byte_cnt) >= burst_bytes() || byte_cnt == 6'd0) begin
                        bus_phase = imra_pkg::PH_STOP_A;
                     end else begin
                        bit_cnt = '0;
                        shreg = '0;
                        bus_phase = imra_pkg::PH_RX_LO;
                     end
                  end
               end
               imra_pkg::PH_STOP_A: bus_phase = imra_pkg::PH_STOP_B;
               imra_pkg::PH_STOP_B: bus_phase = imra_pkg::PH_STOP_C;
               default: bus_phase = imra_pkg::PH_IDLE;
            endcase
         end
      end
      return o;
   endfunction

   // random gaps, none during a window of the run
   function automatic bit take_gap(input int n);
      return !(n >= 700 && n < 1000) && ($urandom_range(0, 99) < IDLE_PCT);
   endfunction

   function automatic imra_pkg::req_type rand_word(input bit with_cmd);
      imra_pkg::req_type w;
      int pick;
      pick = $urandom_range(0, 9);
      w.register_address = 8'($urandom_range(0, 255));
      w.write_data = 8'($urandom_range(0, 255));
      w.sda_in = 1'($urandom_range(0, 1));
      if (!with_cmd || pick < 5) w.cmd = imra_pkg::CMD_NONE;
      else if (pick < 7) w.cmd = imra_pkg::CMD_WRITE;
      else if (pick < 9) w.cmd = imra_pkg::CMD_READ;
      else w.cmd = CMD_UNUSED;
      return w;
   endfunction

   task automatic queue_ticks(input int n, input bit with_cmd);
      repeat (n) words_to_send.push_back(rand_word(with_cmd));
   endtask

   task automatic wait_bus_quiet();
      while (words_to_send.size() != 0 || req_valid || lines_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic put_regs(input logic [3:0] sel, input logic [9:0] dev, input logic [9:0] first,
                           input logic [9:0] len, input logic [9:0] half);
      logic [9:0] vals [4];
      logic [1:0] idx;
      vals = '{dev, first, len, half};
      for (int i = 0; i < 4; i++) begin
         if (sel[i]) begin
            idx = i[1:0];
            @(posedge clock);
            csr_write_enable <= 1'b1;
            csr_index <= idx;
            csr_write_data <= vals[i];
            case (idx)
               imra_pkg::CSR_DEV_ADDR: cfg.device_write_address = vals[i][7:0];
               imra_pkg::CSR_FIRST_REG: cfg.burst_first_register = vals[i][7:0];
               imra_pkg::CSR_BURST_LEN: cfg.burst_length = vals[i][5:0];
               imra_pkg::CSR_HALF_PER: cfg.half_period_ticks = vals[i];
               default: ;
            endcase
         end
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic flag_line(input string what, input imra_pkg::rsp_type want,
                            input imra_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $write("%0t %s: want scl=%b sda=%b busy=%b rv=%b rb=%02h rl=%b, ",
                $realtime, what, want.scl, want.sda_out, want.busy_res, want.read_valid,
                want.read_byte, want.read_last);
         $display("got scl=%b sda=%b busy=%b rv=%b rb=%02h rl=%b",
                  got.scl, got.sda_out, got.busy_res, got.read_valid, got.read_byte,
                  got.read_last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            lines_due.push_back(i2c_tick(req_data));
            sent_words++;
         end
         if (!req_valid || !req_stall) begin
            if (words_to_send.size() != 0 && !take_gap(sent_words)) begin
               req_valid <= 1'b1;
               req_data <= words_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      imra_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_words++;
            if (lines_due.size() == 0) begin
               flag_line("unexpected word", '0, rsp_data);
            end else begin
               want = lines_due.pop_front();
               if (rsp_data.scl !== want.scl || rsp_data.sda_out !== want.sda_out ||
                   rsp_data.busy_res !== want.busy_res ||
                   rsp_data.read_valid !== want.read_valid ||
                   rsp_data.read_byte !== want.read_byte ||
                   rsp_data.read_last !== want.read_last)
                  flag_line("mismatch", want, rsp_data);
            end
         end
         rsp_stall <= take_gap(seen_words);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int random_sent;
      int n;
      random_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default settings, unused command code, command while busy
      words_to_send.push_back(imra_pkg::req_type'{CMD_UNUSED, 8'hff, 8'h00, 1'b1});
      words_to_send.push_back(imra_pkg::req_type'{imra_pkg::CMD_NONE, 8'h00, 8'hff, 1'b0});
      words_to_send.push_back(imra_pkg::req_type'{imra_pkg::CMD_WRITE, 8'hff, 8'h00, 1'b0});
      queue_ticks(25, 1'b1);
      wait_bus_quiet();

      // zero half period mid-segment, read address wrap, zero burst length
      put_regs(4'b1111, 10'd255, 10'd0, 10'd0, 10'd0);
      queue_ticks(70, 1'b0);
      words_to_send.push_back(imra_pkg::req_type'{imra_pkg::CMD_READ, 8'h00, 8'hff, 1'b1});
      queue_ticks(90, 1'b0);
      wait_bus_quiet();

      // 32-byte burst, then shrink the length below the bytes already read
      put_regs(4'b1111, 10'd0, 10'd255, 10'd32, 10'd1);
      words_to_send.push_back(imra_pkg::req_type'{imra_pkg::CMD_READ, 8'h5a, 8'ha5, 1'b0});
      queue_ticks(300, 1'b0);
      wait_bus_quiet();
      put_regs(4'b0100, 10'd0, 10'd0, 10'd3, 10'd0);
      queue_ticks(80, 1'b0);
      wait_bus_quiet();

      // longest half period, cut short by the next settings
      put_regs(4'b1001, 10'd254, 10'd0, 10'd0, 10'd1023);
      words_to_send.push_back(imra_pkg::req_type'{imra_pkg::CMD_WRITE, 8'h5a, 8'ha5, 1'b1});
      queue_ticks(30, 1'b1);
      wait_bus_quiet();

      while (random_sent < RANDOM_WORDS) begin
         n = $urandom_range(20, 150);
         put_regs(4'($urandom_range(0, 15)), 10'($urandom_range(0, 255)),
                  10'($urandom_range(0, 255)),
                  10'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 4)),
                  10'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 3)));
         queue_ticks(n, 1'b1);
         random_sent += n;
         wait_bus_quiet();
      end

      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/imra_pkg.sv
design/imra_csr.sv
design/imra_engine.sv
design/i2c_master_register_access.sv
test/tb.sv
